// ===== rtl/fsfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfl_pkg
// shared types and constants of the fixed slot free list allocator
// ----------------------------------------------------------------------------
package fsfl_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } link_ctl_t;

    // register select bit (paddr[2])
    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic REG_SLOT_BYTES   = 1'b1;

    localparam logic [10:0] SLOTS_RESET = 11'd1024;
    localparam logic [12:0] BYTES_RESET = 13'd64;

endpackage

// ===== rtl/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// pool of equal slots handed out and taken back through a lifo free list
// ----------------------------------------------------------------------------
// usage
//   s_* carries one request: operation (alloc, free, init) and slot_index.
//   m_* returns one result per request: status, granted_index, byte_offset.
//   the apb port sets slots_in_use (0x0) and slot_bytes (0x4); write only
//   while no request is in flight.
// timing
//   the accept cycle reads the link of the list head from the link memory
//   through its registered read port; the execute cycle then updates the
//   head and loads the result register. a new request is taken only after
//   the previous one has left its execute cycle.
// reset
//   the free list is empty and no slot has been handed out, as after init;
//   registers return to 1024 slots of 64 bytes. the link memory is not
//   cleared, no clearing pass is needed.
// stall
//   a held result keeps its register; one further request is taken and
//   waits in its execute cycle until the result register frees up.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[1:0], slot_index[11:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], granted_index[11:2], byte_offset[33:12]
);

    localparam int HEAD_W = $clog2(MAX_SLOTS + 1);
    localparam int AW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [10:0]          slots_in_use_reg;
    logic [12:0]          slot_bytes_reg;
    logic                 cfg_wr;
    logic [10:0]          slot_count;

    fsfl_pkg::link_ctl_t  link_ctl;
    logic [AW-1:0]        link_rd_addr;
    logic [AW-1:0]        link_wr_addr;
    logic [HEAD_W-1:0]    link_wr_data;
    logic [HEAD_W-1:0]    link_rd_data;

    fsfl_pkg::status_t    status;
    logic [9:0]           granted_index;
    logic [21:0]          byte_offset;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= fsfl_pkg::SLOTS_RESET;
            slot_bytes_reg   <= fsfl_pkg::BYTES_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == fsfl_pkg::REG_SLOTS_IN_USE)
            begin
                slots_in_use_reg <= pwdata[10:0];
            end
            else
            begin
                slot_bytes_reg <= pwdata[12:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            fsfl_pkg::REG_SLOTS_IN_USE: prdata = {21'd0, slots_in_use_reg};
            fsfl_pkg::REG_SLOT_BYTES:   prdata = {19'd0, slot_bytes_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // slot count capped at the pool capacity
    assign slot_count = (32'(slots_in_use_reg) > 32'(MAX_SLOTS)) ? 11'(MAX_SLOTS)
                                                                  : slots_in_use_reg;

    fsfl_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .HEAD_W    (HEAD_W),
        .AW        (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .operation     (s_tdata[1:0]),
        .slot_index    (s_tdata[11:2]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .status        (status),
        .granted_index (granted_index),
        .byte_offset   (byte_offset),
        .slot_count    (slot_count),
        .slot_bytes    (slot_bytes_reg),
        .link_ctl      (link_ctl),
        .link_rd_addr  (link_rd_addr),
        .link_wr_addr  (link_wr_addr),
        .link_wr_data  (link_wr_data),
        .link_rd_data  (link_rd_data)
    );

    fsfl_link_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW),
        .DW    (HEAD_W)
    ) u_link_mem (
        .clk     (clk),
        .ctl     (link_ctl),
        .rd_addr (link_rd_addr),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_data (link_rd_data)
    );

    assign m_tdata = {6'd0, byte_offset, granted_index, status};

    // one request at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in execution");

    // a fresh result follows an accepted request
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching request");

    // only an ok result carries a grant
    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != fsfl_pkg::STAT_OK)) |-> (m_tdata[33:2] == 32'd0))
        else $error("grant reported with an error status");

    // nothing is read from the link store while a request executes
    a_link_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        link_ctl.rd_en |-> s_tready)
        else $error("link read outside the accept cycle");

endmodule

// ===== rtl/fsfl_link_mem.sv =====
// ----------------------------------------------------------------------------
// fsfl_link_mem
// link store of the free list, one write and one registered read port
// ----------------------------------------------------------------------------
module fsfl_link_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic                clk,
    input  fsfl_pkg::link_ctl_t ctl,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  logic [DW-1:0]       wr_data,
    output logic [DW-1:0]       rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fsfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsfl_ctrl
// request sequencer: head pointer, untouched counter, link access, result register
// ----------------------------------------------------------------------------
module fsfl_ctrl #(
    parameter int MAX_SLOTS = 1024,
    parameter int HEAD_W    = 11,
    parameter int AW        = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [9:0]            slot_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fsfl_pkg::status_t     status,
    output logic [9:0]            granted_index,
    output logic [21:0]           byte_offset,
    input  logic [10:0]           slot_count,
    input  logic [12:0]           slot_bytes,
    output fsfl_pkg::link_ctl_t   link_ctl,
    output logic [AW-1:0]         link_rd_addr,
    output logic [AW-1:0]         link_wr_addr,
    output logic [HEAD_W-1:0]     link_wr_data,
    input  logic [HEAD_W-1:0]     link_rd_data
);

    localparam logic [HEAD_W-1:0] NULL_MARK = HEAD_W'(MAX_SLOTS);

    fsfl_pkg::ctl_state_t state_reg, state_next;

    logic [1:0]          op_reg;
    logic [9:0]          idx_reg;
    logic [HEAD_W-1:0]   free_head_reg, free_head_next;
    logic [10:0]         untouched_reg, untouched_next;
    logic                out_valid_reg, out_valid_next;
    fsfl_pkg::status_t   out_status_reg, out_status_next;
    logic [9:0]          out_index_reg, out_index_next;
    logic [21:0]         out_offset_reg, out_offset_next;

    logic                accept;
    logic                out_free;
    logic                done;
    logic                head_null;
    logic [10:0]         grant;
    logic [23:0]         product;
    logic                granted;
    logic                free_ok;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign done      = (state_reg == fsfl_pkg::ST_EXEC) && out_free;
    assign head_null = (free_head_reg == NULL_MARK);
    assign free_ok   = ({1'b0, idx_reg} < slot_count);
    assign product   = grant * slot_bytes;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsfl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = fsfl_pkg::ST_EXEC;
                end
            end
            fsfl_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = fsfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fsfl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready       = 1'b0;
        link_ctl.rd_en = 1'b0;
        link_ctl.wr_en = 1'b0;
        case (state_reg)
            fsfl_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                link_ctl.rd_en = in_valid && !head_null;
            end
            fsfl_pkg::ST_EXEC:
            begin
                link_ctl.wr_en = out_free && (fsfl_pkg::op_t'(op_reg) == fsfl_pkg::OP_FREE)
                                 && free_ok;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign link_rd_addr = free_head_reg[AW-1:0];
    assign link_wr_addr = AW'(idx_reg);
    assign link_wr_data = free_head_reg;

    // pool update and result
    always_comb
    begin
        free_head_next  = free_head_reg;
        untouched_next  = untouched_reg;
        out_status_next = fsfl_pkg::STAT_OK;
        grant           = 11'd0;
        granted         = 1'b0;
        case (fsfl_pkg::op_t'(op_reg))
            fsfl_pkg::OP_ALLOC:
            begin
                if (!head_null)
                begin
                    grant          = 11'(free_head_reg);
                    granted        = 1'b1;
                    free_head_next = link_rd_data;
                end
                else if (untouched_reg < slot_count)
                begin
                    grant          = untouched_reg;
                    granted        = 1'b1;
                    untouched_next = untouched_reg + 11'd1;
                end
                else
                begin
                    out_status_next = fsfl_pkg::STAT_EMPTY;
                end
            end
            fsfl_pkg::OP_FREE:
            begin
                if (free_ok)
                begin
                    free_head_next = HEAD_W'(idx_reg);
                end
                else
                begin
                    out_status_next = fsfl_pkg::STAT_RANGE;
                end
            end
            fsfl_pkg::OP_INIT:
            begin
                free_head_next = NULL_MARK;
                untouched_next = 11'd0;
            end
            default:
            begin
                out_status_next = fsfl_pkg::STAT_OK;
            end
        endcase
        out_index_next  = granted ? grant[9:0] : 10'd0;
        out_offset_next = granted ? product[21:0] : 22'd0;
    end

    always_comb
    begin
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsfl_pkg::ST_IDLE;
            free_head_reg <= NULL_MARK;
            untouched_reg <= 11'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (done)
            begin
                free_head_reg <= free_head_next;
                untouched_reg <= untouched_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            idx_reg <= slot_index;
        end
        if (done)
        begin
            out_status_reg <= out_status_next;
            out_index_reg  <= out_index_next;
            out_offset_reg <= out_offset_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_index = out_index_reg;
    assign byte_offset   = out_offset_reg;

endmodule

// ===== sim/tb_fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_slot_free_list_allocator
// self-checking bench for the slot pool: requests go in on the s_* stream,
// results come back on m_*; a local copy of the free list predicts each result
// and the pool size and slot size registers are changed between phases
// ----------------------------------------------------------------------------
module tb_fixed_slot_free_list_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [10:0] POOL_SLOTS  = 11'd1024;
    localparam logic [10:0] NO_SLOT     = 11'd1024;
    localparam logic [2:0]  ADDR_SLOTS  = {fsfl_pkg::REG_SLOTS_IN_USE, 2'b00};
    localparam logic [2:0]  ADDR_BYTES  = {fsfl_pkg::REG_SLOT_BYTES, 2'b00};
    localparam int          HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] idx;
    } pool_req_t;

    typedef struct {
        fsfl_pkg::status_t status;
        logic [9:0]        index;
        logic [21:0]       offset;
        logic              granted;
    } pool_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // operation[1:0], slot_index[11:2], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // status[1:0], granted_index[11:2], byte_offset[33:12]

    // pool shadow
    logic [10:0] head_slot;
    logic [10:0] next_fresh;
    logic [10:0] link_mem [0:1023];
    logic [10:0] cfg_slots;
    logic [12:0] cfg_bytes;

    pool_req_t    req_q[$];
    pool_result_t outcome_q[$];
    logic [9:0]   held_slots[$];

    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_go = 1'b0;
    logic m_hold = 1'b0;

    fixed_slot_free_list_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic pool_result_t step_pool(input logic [1:0] op, input logic [9:0] idx);
        pool_result_t res;
        logic [10:0]  count;
        logic [22:0]  prod;
        count = (cfg_slots > POOL_SLOTS) ? POOL_SLOTS : cfg_slots;
        res.status  = fsfl_pkg::STAT_OK;
        res.index   = '0;
        res.offset  = '0;
        res.granted = 1'b0;
        if (op == fsfl_pkg::OP_ALLOC)
        begin
            if (head_slot < NO_SLOT)
            begin
                res.index   = head_slot[9:0];
                res.granted = 1'b1;
                head_slot   = link_mem[head_slot[9:0]];
            end
            else if (next_fresh < count)
            begin
                res.index   = next_fresh[9:0];
                res.granted = 1'b1;
                next_fresh  = next_fresh + 11'd1;
            end
            else
                res.status = fsfl_pkg::STAT_EMPTY;
        end
        else if (op == fsfl_pkg::OP_FREE)
        begin
            if ({1'b0, idx} < count)
            begin
                link_mem[idx] = head_slot;
                head_slot     = {1'b0, idx};
            end
            else
                res.status = fsfl_pkg::STAT_RANGE;
        end
        else if (op == fsfl_pkg::OP_INIT)
        begin
            head_slot  = NO_SLOT;
            next_fresh = '0;
        end
        if (res.granted)
        begin
            prod       = res.index * cfg_bytes;
            res.offset = prod[21:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                outcome_q.push_back(step_pool(req_q[0].op, req_q[0].idx));
                req_q.delete(0);
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, req_q[0].idx, req_q[0].op};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        pool_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata, 0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[11:2] !== want.index)
                        report_mismatch("granted_index", m_tdata[11:2], want.index);
                    if (m_tdata[33:12] !== want.offset)
                        report_mismatch("byte_offset", m_tdata[33:12], want.offset);
                    if (want.granted)
                        held_slots.push_back(want.index);
                end
            end
            m_tready <= !m_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off so the block backs up
    initial
    begin
        @(posedge clk iff hold_go);
        m_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        int cycles;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL fixed_slot_free_list_allocator");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || outcome_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_pool(input logic [10:0] slots, input logic [12:0] bytes);
        wait_drained();
        apb_write(ADDR_SLOTS, {21'b0, slots});
        apb_write(ADDR_BYTES, {19'b0, bytes});
        cfg_slots = slots;
        cfg_bytes = bytes;
        @(negedge clk);
    endtask

    task automatic add_req(input logic [1:0] op, input logic [9:0] idx);
        pool_req_t r;
        r.op  = op;
        r.idx = idx;
        req_q.push_back(r);
    endtask

    // mostly alloc and free of slots actually held, plus noise
    task automatic queue_random(input int n);
        pool_req_t r;
        int        pick;
        int        eff;
        int        k;
        held_slots.delete();
        add_req(fsfl_pkg::OP_INIT, 10'($urandom));
        repeat (n)
        begin
            while (req_q.size() >= 4) @(negedge clk);
            eff   = (cfg_slots > POOL_SLOTS) ? POOL_SLOTS : cfg_slots;
            pick  = $urandom_range(99);
            r.op  = fsfl_pkg::OP_ALLOC;
            r.idx = 10'($urandom);
            if (pick < 45)
                r.op = fsfl_pkg::OP_ALLOC;
            else if (pick < 82)
            begin
                if (held_slots.size() != 0)
                begin
                    k     = $urandom_range(held_slots.size() - 1);
                    r.op  = fsfl_pkg::OP_FREE;
                    r.idx = held_slots[k];
                    held_slots.delete(k);
                end
            end
            else if (pick < 87 && eff != 0)
            begin
                r.op  = fsfl_pkg::OP_FREE;
                r.idx = 10'($urandom_range(eff - 1));
            end
            else if (pick < 92 && eff < 1024)
            begin
                r.op  = fsfl_pkg::OP_FREE;
                r.idx = 10'($urandom_range(1023, eff));
            end
            else if (pick < 97)
                r.op = OP_UNUSED;
            else
            begin
                r.op = fsfl_pkg::OP_INIT;
                held_slots.delete();
            end
            req_q.push_back(r);
        end
    endtask

    initial
    begin
        head_slot  = NO_SLOT;
        next_fresh = '0;
        cfg_slots  = fsfl_pkg::SLOTS_RESET;
        cfg_bytes  = fsfl_pkg::BYTES_RESET;
        send_idle_pct = 29;
        recv_idle_pct = 68;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: lifo order, untouched slots, top slot
        add_req(fsfl_pkg::OP_INIT, 10'h3ff);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(fsfl_pkg::OP_ALLOC, 10'h3ff);
        add_req(fsfl_pkg::OP_ALLOC, 10'h155);
        add_req(fsfl_pkg::OP_FREE, 10'd1);
        add_req(fsfl_pkg::OP_FREE, 10'd0);
        add_req(fsfl_pkg::OP_ALLOC, 10'h2aa);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(fsfl_pkg::OP_FREE, 10'h3ff);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(OP_UNUSED, 10'h3ff);
        add_req(fsfl_pkg::OP_FREE, 10'h2aa);
        add_req(fsfl_pkg::OP_ALLOC, 10'h155);

        // two slots: exhaustion and out of range frees
        set_pool(11'd2, 13'd4096);
        add_req(fsfl_pkg::OP_INIT, 10'h000);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(fsfl_pkg::OP_FREE, 10'd2);
        add_req(fsfl_pkg::OP_FREE, 10'h3ff);
        add_req(fsfl_pkg::OP_FREE, 10'd1);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);

        // count above the pool size clamps, offset truncates
        set_pool(11'h7ff, 13'h1fff);
        add_req(fsfl_pkg::OP_FREE, 10'h3ff);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);

        // empty pool
        set_pool(11'd0, 13'd0);
        add_req(fsfl_pkg::OP_ALLOC, 10'h000);
        add_req(fsfl_pkg::OP_FREE, 10'h000);

        set_pool(11'd1024, 13'd64);
        queue_random(300);
        set_pool(11'd5, 13'd4096);
        queue_random(150);

        wait_drained();
        send_idle_pct = 68;
        recv_idle_pct = 29;
        set_pool(11'h7ff, 13'h1fff);
        queue_random(300);
        set_pool(11'd1, 13'd1);
        queue_random(100);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_pool(11'd300, 13'($urandom_range(1, 8191)));
        hold_go = 1'b1;
        queue_random(300);
        set_pool(11'd1024, 13'd4096);
        queue_random(300);
        set_pool(11'd0, 13'd0);
        queue_random(50);

        wait_drained();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("PASS fixed_slot_free_list_allocator");
        else
            $display("FAIL fixed_slot_free_list_allocator");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fsfl_pkg.sv
rtl/fsfl_link_mem.sv
rtl/fsfl_ctrl.sv
rtl/fixed_slot_free_list_allocator.sv
sim/tb_fixed_slot_free_list_allocator.sv
